@@ design/fsp_pkg.sv @@
package fsp_pkg;

    // Default pool size
    localparam int SLOTS_DEF = 3;

    // Field widths
    localparam int KIND_W   = 3;
    localparam int SLOT_W   = 3;
    localparam int HANDLE_W = 32;
    localparam int LEN_W    = 24;
    localparam int NUM_W    = 32;
    localparam int STATUS_W = 3;

    typedef enum logic [KIND_W-1:0] {
        K_ALLOC   = 3'd0,
        K_FILL    = 3'd1,
        K_READ    = 3'd2,
        K_RELEASE = 3'd3,
        K_FLUSH   = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        RS_OK       = 3'd0,
        RS_NONE     = 3'd1,
        RS_SMALL    = 3'd2,
        RS_UNKNOWN  = 3'd3,
        RS_BADSTATE = 3'd4
    } rsp_status_t;

    typedef enum logic [1:0] {
        SS_FREE   = 2'd0,
        SS_PREP   = 2'd1,
        SS_READY  = 2'd2,
        SS_CLIENT = 2'd3
    } slot_st_t;

endpackage

@@ design/frame_slot_pool_top.sv @@
// Requests wait in the input register, held there by a stalled result or an unfinished flush;
// throughput is one request word per cycle otherwise. Allocate, fill, read and release give one
// result word; a flush gives one per held slot, at least one; undefined kinds give none.
// The input register and the result register each hold one word, so a request is taken
// while a result waits. Reset (rst_n low, asynchronous) frees every slot, clears the
// frame counter and selects copy mode; slot payload storage is not cleared.
module frame_slot_pool_top
    import fsp_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)(
    input  logic                clk,
    input  logic                rst_n,

    // configuration: disposable mode bit
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,

    // request words
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [KIND_W-1:0]   kind,
    input  logic [SLOT_W-1:0]   slot,
    input  logic [HANDLE_W-1:0] buffer_handle,
    input  logic [LEN_W-1:0]    byte_length,
    input  logic                has_destination,
    input  logic [LEN_W-1:0]    destination_capacity,

    // result words
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [STATUS_W-1:0] status,
    output logic [SLOT_W-1:0]   slot_index,
    output logic [NUM_W-1:0]    frame_number,
    output logic [HANDLE_W-1:0] handle_out,
    output logic [LEN_W-1:0]    length_out,
    output logic                give_back,
    output logic                last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // ------------------------------------------------------------------
    // Configuration register. Users must send writes only while the pool is idle; not enforced.
    // ------------------------------------------------------------------
    logic mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            mode_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Input register: hold one request word until its last result is registered.
    // ------------------------------------------------------------------
    logic                ir_valid_reg;
    logic [KIND_W-1:0]   ir_kind_reg;
    logic [SLOT_W-1:0]   ir_slot_reg;
    logic [HANDLE_W-1:0] ir_handle_reg;
    logic [LEN_W-1:0]    ir_len_reg;
    logic                ir_has_dst_reg;
    logic [LEN_W-1:0]    ir_cap_reg;

    logic fire;        // process one step of the held request this cycle
    logic item_done;   // the held request is finished this cycle
    logic produce;     // this step emits a result word
    logic step_last;   // this step is the last one of the request

    assign req_ready = !ir_valid_reg || item_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            ir_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            ir_kind_reg    <= kind;
            ir_slot_reg    <= slot;
            ir_handle_reg  <= buffer_handle;
            ir_len_reg     <= byte_length;
            ir_has_dst_reg <= has_destination;
            ir_cap_reg     <= destination_capacity;
        end
    end

    // ------------------------------------------------------------------
    // Pool state. Slot payload storage has no reset: a slot is only read
    // after it was allocated and filled.
    // ------------------------------------------------------------------
    slot_st_t            st_reg  [SLOTS];
    slot_st_t            st_next [SLOTS];
    logic [NUM_W-1:0]    num_reg [SLOTS];
    logic [HANDLE_W-1:0] buf_reg [SLOTS];
    logic [LEN_W-1:0]    len_reg [SLOTS];
    logic [NUM_W-1:0]    counter_reg;
    logic [NUM_W-1:0]    counter_next;

    // ------------------------------------------------------------------
    // Slot selection. All slots are examined side by side.
    // ------------------------------------------------------------------
    logic [SLOTS-1:0] free_mask;
    logic [SLOTS-1:0] ready_mask;
    logic [SLOTS-1:0] held_mask;
    logic [SLOTS-1:0] rd_win;
    logic [SLOTS-1:0] held_rest;
    logic             free_any;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] fl_idx;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            free_mask[i]  = (st_reg[i] == SS_FREE);
            ready_mask[i] = (st_reg[i] == SS_READY);
            held_mask[i]  = (st_reg[i] == SS_READY) || (st_reg[i] == SS_CLIENT);
        end
    end

    // Lowest free slot for allocate, lowest held slot for flush.
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        fl_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (free_mask[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
            if (held_mask[i])
            begin
                fl_idx = IDX_W'(i);
            end
        end
    end

    // Held slots left once the lowest one is emitted.
    assign held_rest = held_mask & (held_mask - SLOTS'(1));

    // Oldest ready slot: a slot wins when its number is below every other
    // ready slot's, ties going to the lower index. Exactly one slot wins
    // whenever any slot is ready.
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            rd_win[i] = ready_mask[i];
            for (int j = 0; j < SLOTS; j++)
            begin
                if (j != i && ready_mask[j])
                begin
                    if (j < i)
                    begin
                        rd_win[i] = rd_win[i] && (num_reg[i] < num_reg[j]);
                    end
                    else
                    begin
                        rd_win[i] = rd_win[i] && (num_reg[i] <= num_reg[j]);
                    end
                end
            end
        end
        rd_idx = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (rd_win[i])
            begin
                rd_idx = rd_idx | IDX_W'(i);
            end
        end
    end

    // ------------------------------------------------------------------
    // One read port into slot storage, steered by the request kind.
    // ------------------------------------------------------------------
    logic             slot_in_range;
    logic [IDX_W-1:0] req_idx;
    logic [IDX_W-1:0] sel_idx;
    slot_st_t         sel_st;
    logic [NUM_W-1:0]    sel_num;
    logic [HANDLE_W-1:0] sel_buf;
    logic [LEN_W-1:0]    sel_len;

    assign slot_in_range = (32'(ir_slot_reg) < SLOTS);
    assign req_idx       = IDX_W'(ir_slot_reg);

    always_comb
    begin
        unique case (kind_t'(ir_kind_reg))
            K_READ:  sel_idx = rd_idx;
            K_FLUSH: sel_idx = fl_idx;
            default: sel_idx = slot_in_range ? req_idx : '0;
        endcase
    end

    assign sel_st  = st_reg[sel_idx];
    assign sel_num = num_reg[sel_idx];
    assign sel_buf = buf_reg[sel_idx];
    assign sel_len = len_reg[sel_idx];

    // ------------------------------------------------------------------
    // Result and next state for one step of the held request.
    // ------------------------------------------------------------------
    rsp_status_t         r_status;
    logic [SLOT_W-1:0]   r_idx;
    logic [NUM_W-1:0]    r_num;
    logic [HANDLE_W-1:0] r_handle;
    logic [LEN_W-1:0]    r_len;
    logic                r_back;
    logic                wr_num;   // allocate writes a new frame number
    logic                wr_fill;  // fill done stores handle and length

    always_comb
    begin
        r_status     = RS_OK;
        r_idx        = '0;
        r_num        = '0;
        r_handle     = '0;
        r_len        = '0;
        r_back       = 1'b0;
        produce      = 1'b1;
        step_last    = 1'b1;
        wr_num       = 1'b0;
        wr_fill      = 1'b0;
        counter_next = counter_reg;
        for (int i = 0; i < SLOTS; i++)
        begin
            st_next[i] = st_reg[i];
        end

        unique case (ir_kind_reg)
            K_ALLOC:
            begin
                if (free_any)
                begin
                    counter_next      = counter_reg + NUM_W'(1);
                    st_next[free_idx] = SS_PREP;
                    wr_num            = 1'b1;
                    r_idx             = SLOT_W'(free_idx);
                    r_num             = counter_next;
                end
                else
                begin
                    r_status = RS_NONE;
                    r_handle = ir_handle_reg;
                    r_back   = 1'b1;
                end
            end
            K_FILL:
            begin
                r_idx = ir_slot_reg;
                if (slot_in_range && sel_st == SS_PREP)
                begin
                    st_next[sel_idx] = SS_READY;
                    wr_fill          = 1'b1;
                    r_num            = sel_num;
                    r_handle         = ir_handle_reg;
                    r_len            = ir_len_reg;
                end
                else
                begin
                    r_status = RS_BADSTATE;
                    r_handle = ir_handle_reg;
                    r_back   = 1'b1;
                end
            end
            K_READ:
            begin
                if (ready_mask == '0)
                begin
                    r_status = RS_NONE;
                end
                else
                begin
                    r_idx    = SLOT_W'(rd_idx);
                    r_num    = sel_num;
                    r_handle = sel_buf;
                    r_len    = sel_len;
                    if (mode_reg)
                    begin
                        st_next[rd_idx] = SS_CLIENT;
                    end
                    else if (ir_has_dst_reg && ir_cap_reg < sel_len)
                    begin
                        r_status = RS_SMALL;
                    end
                    else
                    begin
                        st_next[rd_idx] = SS_FREE;
                        r_back          = 1'b1;
                    end
                end
            end
            K_RELEASE:
            begin
                r_idx = ir_slot_reg;
                if (slot_in_range && (sel_st == SS_READY || sel_st == SS_CLIENT))
                begin
                    st_next[sel_idx] = SS_FREE;
                    r_num            = sel_num;
                    r_handle         = sel_buf;
                    r_len            = sel_len;
                    r_back           = 1'b1;
                end
                else
                begin
                    r_status = RS_UNKNOWN;
                end
            end
            K_FLUSH:
            begin
                // Emit the lowest held slot and drop it; free all on the last step.
                if (held_mask != '0)
                begin
                    r_idx           = SLOT_W'(fl_idx);
                    r_num           = sel_num;
                    r_handle        = sel_buf;
                    r_len           = sel_len;
                    r_back          = 1'b1;
                    step_last       = (held_rest == '0);
                    st_next[fl_idx] = SS_FREE;
                end
                if (step_last)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        st_next[i] = SS_FREE;
                    end
                end
            end
            default:
            begin
                // Undefined kinds are dropped without a result.
                produce = 1'b0;
            end
        endcase
    end

    assign fire      = ir_valid_reg && (!produce || !rsp_valid || rsp_ready);
    assign item_done = fire && step_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                st_reg[i] <= SS_FREE;
            end
        end
        else if (fire)
        begin
            counter_reg <= counter_next;
            for (int i = 0; i < SLOTS; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && wr_num)
        begin
            num_reg[free_idx] <= counter_next;
        end
        if (fire && wr_fill)
        begin
            buf_reg[sel_idx] <= ir_handle_reg;
            len_reg[sel_idx] <= ir_len_reg;
        end
    end

    // ------------------------------------------------------------------
    // Result register: hold the word until the consumer takes it.
    // ------------------------------------------------------------------
    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [SLOT_W-1:0]   slot_index_reg;
    logic [NUM_W-1:0]    frame_number_reg;
    logic [HANDLE_W-1:0] handle_out_reg;
    logic [LEN_W-1:0]    length_out_reg;
    logic                give_back_reg;
    logic                last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (fire && produce)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && produce)
        begin
            status_reg       <= r_status;
            slot_index_reg   <= r_idx;
            frame_number_reg <= r_num;
            handle_out_reg   <= r_handle;
            length_out_reg   <= r_len;
            give_back_reg    <= r_back;
            last_reg         <= step_last;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign slot_index   = slot_index_reg;
    assign frame_number = frame_number_reg;
    assign handle_out   = handle_out_reg;
    assign length_out   = length_out_reg;
    assign give_back    = give_back_reg;
    assign last         = last_reg;

endmodule

@@ design/fsp_checker.sv @@
module fsp_checker
    import fsp_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] status,
    input logic [SLOT_W-1:0]   slot_index,
    input logic [NUM_W-1:0]    frame_number,
    input logic [HANDLE_W-1:0] handle_out,
    input logic [LEN_W-1:0]    length_out,
    input logic                give_back,
    input logic                last
);

    // A stalled result word holds its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(slot_index)
            && $stable(frame_number) && $stable(handle_out) && $stable(length_out)
            && $stable(give_back) && $stable(last))
        else $error("result word changed while stalled");

    // A too-small read keeps the buffer in the pool.
    a_small_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == RS_SMALL |-> !give_back && last)
        else $error("too-small read returned its buffer");

    // An unknown release carries nothing but the slot echo.
    a_unknown_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == RS_UNKNOWN |->
            frame_number == '0 && handle_out == '0 && length_out == '0 && !give_back)
        else $error("unknown release carried payload");

    // None available never names a slot or a frame.
    a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == RS_NONE |->
            slot_index == '0 && frame_number == '0 && length_out == '0 && last)
        else $error("none-available result names a slot");

    // The mode register never back-pressures.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind frame_slot_pool_top fsp_checker u_fsp_checker (.*);

@@ tb/testbench.sv @@
module testbench;
    import fsp_pkg::*;

    localparam int SLOTS = SLOTS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SHOWN_MAX = 10;

    // One request word as it sits on the request channel.
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [SLOT_W-1:0]   slot;
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    blen;
        logic                dst;
        logic [LEN_W-1:0]    cap;
    } req_t;

    // One result word, field for field as on the result channel.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   idx;
        logic [NUM_W-1:0]    num;
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    len;
        logic                back;
        logic                last;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic cfg_valid = 1'b0;
    logic cfg_data = 1'b0;
    logic cfg_ready;

    req_t cur = '0;
    logic req_valid = 1'b0;
    logic req_ready;

    logic rsp_ready = 1'b0;
    logic rsp_valid;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic [NUM_W-1:0]    frame_number;
    logic [HANDLE_W-1:0] handle_out;
    logic [LEN_W-1:0]    length_out;
    logic                give_back;
    logic                last;

    frame_slot_pool_top #(.SLOTS(SLOTS)) uut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_data             (cfg_data),
        .req_valid            (req_valid),
        .req_ready            (req_ready),
        .kind                 (cur.kind),
        .slot                 (cur.slot),
        .buffer_handle        (cur.handle),
        .byte_length          (cur.blen),
        .has_destination      (cur.dst),
        .destination_capacity (cur.cap),
        .rsp_valid            (rsp_valid),
        .rsp_ready            (rsp_ready),
        .status               (status),
        .slot_index           (slot_index),
        .frame_number         (frame_number),
        .handle_out           (handle_out),
        .length_out           (length_out),
        .give_back            (give_back),
        .last                 (last)
    );

    // Shadow copy of the pool, advanced at each accepted request word.
    slot_st_t            pool_state [SLOTS];
    logic [NUM_W-1:0]    pool_frame [SLOTS];
    logic [HANDLE_W-1:0] pool_handle [SLOTS];
    logic [LEN_W-1:0]    pool_len [SLOTS];
    logic [NUM_W-1:0]    frame_ctr = '0;
    logic                disp_mode = 1'b0;

    req_t    pending_reqs [$];
    result_t due_results [$];

    int  words_sent = 0;
    int  words_taken = 0;
    int  mismatches = 0;
    int  cycle_count = 0;
    logic req_fire = 1'b0;
    int  req_gap = 0;
    int  rsp_stall = 0;
    bit  calm = 1'b0;

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            pool_state[i] = SS_FREE;
            pool_frame[i] = '0;
            pool_handle[i] = '0;
            pool_len[i] = '0;
        end
    end

    initial begin
        forever #6 clk = ~clk;
    end

    // Work out the result words one request word causes and queue them.
    task automatic step_pool(req_t r);
        result_t outs [$];
        result_t w;
        int pick;
        int i;
        pick = -1;
        w = '0;
        case (r.kind)
            K_ALLOC: begin
                for (i = 0; i < SLOTS; i++)
                    if (pick < 0 && pool_state[i] == SS_FREE)
                        pick = i;
                if (pick < 0) begin
                    w.status = RS_NONE;
                    w.handle = r.handle;
                    w.back = 1'b1;
                end
                else begin
                    frame_ctr = frame_ctr + 1'b1;
                    pool_frame[pick] = frame_ctr;
                    pool_state[pick] = SS_PREP;
                    w.status = RS_OK;
                    w.idx = SLOT_W'(pick);
                    w.num = frame_ctr;
                end
                outs.push_back(w);
            end
            K_FILL: begin
                if (r.slot < SLOTS && pool_state[r.slot] == SS_PREP) begin
                    pool_handle[r.slot] = r.handle;
                    pool_len[r.slot] = r.blen;
                    pool_state[r.slot] = SS_READY;
                    w.status = RS_OK;
                    w.num = pool_frame[r.slot];
                    w.len = r.blen;
                end
                else begin
                    w.status = RS_BADSTATE;
                    w.back = 1'b1;
                end
                w.idx = r.slot;
                w.handle = r.handle;
                outs.push_back(w);
            end
            K_READ: begin
                // oldest ready frame wins, lowest index on a tie
                for (i = 0; i < SLOTS; i++)
                    if (pool_state[i] == SS_READY &&
                        (pick < 0 || pool_frame[pick] > pool_frame[i]))
                        pick = i;
                if (pick < 0)
                    w.status = RS_NONE;
                else begin
                    w.idx = SLOT_W'(pick);
                    w.num = pool_frame[pick];
                    w.handle = pool_handle[pick];
                    w.len = pool_len[pick];
                    if (disp_mode) begin
                        pool_state[pick] = SS_CLIENT;
                        w.status = RS_OK;
                    end
                    else if (r.dst && r.cap < pool_len[pick])
                        w.status = RS_SMALL;
                    else begin
                        pool_state[pick] = SS_FREE;
                        w.status = RS_OK;
                        w.back = 1'b1;
                    end
                end
                outs.push_back(w);
            end
            K_RELEASE: begin
                w.idx = r.slot;
                if (r.slot < SLOTS &&
                    (pool_state[r.slot] == SS_READY || pool_state[r.slot] == SS_CLIENT)) begin
                    pool_state[r.slot] = SS_FREE;
                    w.status = RS_OK;
                    w.num = pool_frame[r.slot];
                    w.handle = pool_handle[r.slot];
                    w.len = pool_len[r.slot];
                    w.back = 1'b1;
                end
                else
                    w.status = RS_UNKNOWN;
                outs.push_back(w);
            end
            K_FLUSH: begin
                for (i = 0; i < SLOTS; i++) begin
                    if (pool_state[i] == SS_READY || pool_state[i] == SS_CLIENT) begin
                        w = '0;
                        w.status = RS_OK;
                        w.idx = SLOT_W'(i);
                        w.num = pool_frame[i];
                        w.handle = pool_handle[i];
                        w.len = pool_len[i];
                        w.back = 1'b1;
                        outs.push_back(w);
                    end
                    pool_state[i] = SS_FREE;
                end
                // empty pool still answers with one plain ok word
                if (outs.size() == 0) begin
                    w = '0;
                    w.status = RS_OK;
                    outs.push_back(w);
                end
            end
            default: ;
        endcase
        if (outs.size() > 0) begin
            outs[outs.size() - 1].last = 1'b1;
            foreach (outs[k])
                due_results.push_back(outs[k]);
        end
    endtask

    task automatic report_word(string what, result_t want, result_t got);
        mismatches++;
        if (mismatches <= SHOWN_MAX) begin
            $display("%s: want st=%0d slot=%0d num=%0h handle=%0h len=%0h back=%0b last=%0b",
                     what, want.status, want.idx, want.num, want.handle, want.len,
                     want.back, want.last);
            $display("%s:  got st=%0d slot=%0d num=%0h handle=%0h len=%0h back=%0b last=%0b",
                     what, got.status, got.idx, got.num, got.handle, got.len,
                     got.back, got.last);
        end
    endtask

    // Sample every handshake at the rising edge: mode writes, request words
    // into the shadow pool, result words against the oldest one due.
    always @(posedge clk) begin
        result_t got;
        result_t want;
        req_fire <= req_valid && req_ready;
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                disp_mode = cfg_data;
            if (req_valid && req_ready) begin
                words_taken++;
                step_pool(cur);
            end
            if (rsp_valid && rsp_ready) begin
                got = {status, slot_index, frame_number, handle_out, length_out,
                       give_back, last};
                if (due_results.size() == 0)
                    report_word("unexpected word", '0, got);
                else begin
                    want = due_results.pop_front();
                    if (got.status !== want.status || got.idx !== want.idx ||
                        got.num !== want.num || got.handle !== want.handle ||
                        got.len !== want.len || got.back !== want.back ||
                        got.last !== want.last)
                        report_word("mismatch", want, got);
                end
            end
        end
    end

    // Request driver: hold the word until taken, then advance or idle a burst.
    always @(negedge clk) begin
        if (rst_n && (!req_valid || req_fire)) begin
            if (req_gap > 0) begin
                req_gap <= req_gap - 1;
                req_valid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0) begin
                req_gap <= $urandom_range(0, 14);
                req_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0) begin
                cur <= pending_reqs.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Result side: stall in random bursts, starting none once the run turns calm.
    always @(negedge clk) begin
        if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 6) == 0) begin
            rsp_stall <= $urandom_range(0, 14);
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic send(logic [KIND_W-1:0] k, logic [SLOT_W-1:0] s,
                        logic [HANDLE_W-1:0] h, logic [LEN_W-1:0] n,
                        logic d, logic [LEN_W-1:0] c);
        pending_reqs.push_back('{k, s, h, n, d, c});
        words_sent++;
    endtask

    // Pick a request word that mostly fits the pool as it stands now, so
    // fills hit preparing slots and releases hit held ones; the rest is noise.
    function automatic req_t invent_request();
        req_t r;
        int roll;
        int i;
        int cand [$];
        r.kind = K_ALLOC;
        r.slot = SLOT_W'($urandom_range(0, 7));
        r.handle = $urandom;
        r.blen = LEN_W'($urandom);
        r.dst = 1'($urandom_range(0, 1));
        r.cap = LEN_W'($urandom);
        if ($urandom_range(0, 3) == 0)
            r.blen = LEN_W'($urandom_range(0, 16));
        roll = $urandom_range(0, 99);
        if (roll < 28)
            r.kind = K_ALLOC;
        else if (roll < 52) begin
            r.kind = K_FILL;
            for (i = 0; i < SLOTS; i++)
                if (pool_state[i] == SS_PREP)
                    cand.push_back(i);
            if (cand.size() > 0 && $urandom_range(0, 6) != 0)
                r.slot = SLOT_W'(cand[$urandom_range(0, cand.size() - 1)]);
        end
        else if (roll < 72) begin
            r.kind = K_READ;
            for (i = 0; i < SLOTS; i++)
                if (pool_state[i] == SS_READY)
                    cand.push_back(i);
            // land the capacity right around a stored length
            if (cand.size() > 0 && $urandom_range(0, 1) == 1)
                r.cap = pool_len[cand[$urandom_range(0, cand.size() - 1)]] +
                        LEN_W'($urandom_range(0, 2)) - 1'b1;
        end
        else if (roll < 84) begin
            r.kind = K_RELEASE;
            for (i = 0; i < SLOTS; i++)
                if (pool_state[i] == SS_READY || pool_state[i] == SS_CLIENT)
                    cand.push_back(i);
            if (cand.size() > 0 && $urandom_range(0, 4) != 0)
                r.slot = SLOT_W'(cand[$urandom_range(0, cand.size() - 1)]);
        end
        else if (roll < 90)
            r.kind = K_FLUSH;
        else if (roll < 94)
            r.kind = KIND_W'($urandom_range(5, 7));
        else
            r.kind = KIND_W'($urandom_range(0, 4));
        return r;
    endfunction

    task automatic run_random(int count);
        req_t r;
        int made;
        made = 0;
        while (made < count) begin
            @(negedge clk);
            if (pending_reqs.size() < 2) begin
                r = invent_request();
                send(r.kind, r.slot, r.handle, r.blen, r.dst, r.cap);
                if (r.kind <= K_FLUSH)
                    made++;
            end
        end
    endtask

    // Wait until every word sent is taken and every result word is in.
    task automatic wait_drained;
        do
            @(negedge clk);
        while (words_taken != words_sent || due_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_mode(logic v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Copy mode: empty pool, bad indexes, ignored kinds, pool full,
        // extreme handles and lengths, capacity one short and exact.
        send(K_READ, 3'd0, '0, '0, 1'b0, '0);
        send(K_RELEASE, 3'd0, '0, '0, 1'b0, '0);
        send(K_RELEASE, 3'd7, '1, '1, 1'b1, '1);
        send(K_FILL, 3'd0, '1, '1, 1'b0, '0);
        send(K_FILL, 3'd7, 32'h5A5A_5A5A, 24'h00_0010, 1'b0, '0);
        send(K_FLUSH, 3'd0, '0, '0, 1'b0, '0);
        send(3'd5, 3'd1, '1, '1, 1'b1, '1);
        send(3'd7, 3'd2, '0, '0, 1'b0, '0);
        send(K_ALLOC, 3'd0, $urandom, '0, 1'b0, '0);
        send(K_ALLOC, 3'd0, $urandom, '0, 1'b0, '0);
        send(K_ALLOC, 3'd0, $urandom, '0, 1'b0, '0);
        send(K_ALLOC, 3'd0, '1, '0, 1'b0, '0);
        send(K_FILL, 3'd0, '1, '1, 1'b0, '0);
        send(K_FILL, 3'd1, '0, '0, 1'b0, '0);
        send(K_FILL, 3'd2, 32'hA5A5_A5A5, 24'd100, 1'b0, '0);
        send(K_FILL, 3'd1, 32'h1234_5678, 24'd7, 1'b0, '0);
        send(K_READ, 3'd0, '0, '0, 1'b1, 24'hFF_FFFE);
        send(K_READ, 3'd0, '0, '0, 1'b1, '1);
        send(K_READ, 3'd0, '0, '0, 1'b0, '0);
        send(K_RELEASE, 3'd2, '0, '0, 1'b0, '0);
        send(K_RELEASE, 3'd2, '0, '0, 1'b0, '0);
        send(K_ALLOC, 3'd0, '0, '0, 1'b0, '0);
        send(K_FILL, 3'd0, 32'hDEAD_0001, 24'd33, 1'b0, '0);
        send(K_ALLOC, 3'd0, '0, '0, 1'b0, '0);
        send(K_FILL, 3'd1, 32'hDEAD_0002, 24'd44, 1'b0, '0);
        send(K_ALLOC, 3'd0, '0, '0, 1'b0, '0);
        send(K_FLUSH, 3'd0, '0, '0, 1'b0, '0);
        wait_drained();

        // Disposable mode: a read hands the slot out even with a tiny buffer.
        write_mode(1'b1);
        send(K_ALLOC, 3'd0, '0, '0, 1'b0, '0);
        send(K_FILL, 3'd0, 32'hC0DE_0003, 24'd5, 1'b0, '0);
        send(K_READ, 3'd0, '0, '0, 1'b1, '0);
        send(K_FLUSH, 3'd0, '0, '0, 1'b0, '0);
        run_random(150);
        wait_drained();

        write_mode(1'b0);
        run_random(150);
        wait_drained();

        write_mode(1'b1);
        run_random(80);
        wait_drained();

        // Last stretch runs at full rate on both sides.
        calm = 1'b1;
        write_mode(1'b0);
        run_random(90);
        wait_drained();
        repeat (8) @(negedge clk);

        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
